[rtl/chained_hash_set_defines.svh]
// ----------------------------------------------------------------------------
// chained_hash_set_defines.svh
// Assertion macros shared by the hash set checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_DEFINES_SVH
`define CHAINED_HASH_SET_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define CHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset.
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/chs_pkg.sv]
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types, sizes and state codes of the chained hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

    localparam int BUCKETS    = 1024;
    localparam int POOL_NODES = 4096;

    localparam int KEY_W   = 32;
    localparam int CFG_W   = 11;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int USED_W  = NODE_W + 1;
    localparam int DIG_W   = 4;
    localparam int MOD_STEPS = KEY_W / DIG_W;
    localparam int STEP_W  = $clog2(MOD_STEPS);

    localparam int CFG_RESET = 1021;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HEAD,
        ST_WALK,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    typedef enum logic {
        ACT_FIND   = 1'b0,
        ACT_INSERT = 1'b1
    } action_t;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] idx;
    } ptr_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        ptr_t             link;
    } node_t;

    typedef struct packed {
        action_t          action;
        logic [KEY_W-1:0] key;
        logic [CFG_W-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic              found;
        logic              inserted;
        logic              pool_full;
        logic [NODE_W-1:0] node_index;
    } res_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

endpackage

`default_nettype wire

[rtl/chained_hash_set.sv]
// ----------------------------------------------------------------------------
// chained_hash_set
// Set of 32-bit keys in buckets with separate chaining: find and insert.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   s_tuser action, s_tdata key
//  m_        out        m_tvalid / m_tready   m_tdata found..node_index
//  cfg_      in         cfg_valid / cfg_ready cfg_data bucket_count
//
//  From accept to result the item passes the remainder unit (four key bits a
//  cycle), the bucket head read, the pick-up of the head, a read per chain node
//  visited, the update step (skipped when the key is found) and the load of the
//  output register. The next item can be accepted once the engine has handed
//  its result to the output register.
//  After reset a clearing pass empties the 1024 bucket heads; s_tready stays
//  low until it ends. Configuration writes are taken always.
//  The output register holds a result while m_tready is low; a new item is
//  accepted meanwhile and waits in the engine once its result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_set (
    input  wire         clk,
    input  wire         rst_n,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] key
    input  wire  [0:0]  s_tuser,   // [0] action
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [0] found, [1] inserted, [2] pool_full,
                                   // [14:3] node_index, [15] zero
    // configuration
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [10:0] cfg_data   // bucket_count
);
    import chs_pkg::*;

    logic [CFG_W-1:0] bcount_reg, bcount_next;
    logic [CFG_W-1:0] eff_count;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_data_reg, out_data_next;
    logic             start;
    logic             res_take;
    req_t             req;
    res_t             res;
    eng_stat_t        stat;

    // Clamp the bucket count into the supported range.
    always_comb
    begin
        if (bcount_reg < CFG_W'(2))
        begin
            eff_count = CFG_W'(2);
        end
        else if (bcount_reg > CFG_W'(BUCKETS))
        begin
            eff_count = CFG_W'(BUCKETS);
        end
        else
        begin
            eff_count = bcount_reg;
        end
    end

    assign cfg_ready   = 1'b1;
    assign bcount_next = cfg_valid ? cfg_data : bcount_reg;

    assign s_tready   = stat.idle;
    assign start      = s_tvalid && stat.idle;
    assign req = '{action: action_t'(s_tuser[0]), key: s_tdata, divisor: eff_count};

    // Hand the result over when the output register is empty or draining.
    assign res_take = stat.res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, res.node_index, res.pool_full, res.inserted, res.found};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg    <= CFG_W'(CFG_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bcount_reg    <= bcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    chs_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .res_take (res_take),
        .res      (res),
        .stat     (stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/chs_mod.sv]
// ----------------------------------------------------------------------------
// chs_mod
// Iterative remainder unit: key mod divisor, four key bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_mod (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    input  wire [chs_pkg::KEY_W-1:0]      dividend,
    input  wire [chs_pkg::CFG_W-1:0]      divisor,
    output logic                          done,
    output logic [chs_pkg::BKT_W-1:0]     rem
);
    import chs_pkg::*;

    logic [KEY_W-1:0]  shift_reg, shift_next;
    logic [BKT_W-1:0]  rem_reg, rem_next;
    logic [CFG_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // Unrolled compare-subtract chain: one restoring step per key bit.
    always_comb
    begin
        logic [BKT_W:0] t;
        logic [BKT_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIG_W; i++)
        begin
            t = {r, shift_reg[KEY_W-1-i]};
            if (t >= div_reg)
            begin
                t = t - div_reg;
            end
            r = t[BKT_W-1:0];
        end
        rem_next   = rem_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = r;
            shift_next = shift_reg << DIG_W;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        div_reg   <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

[rtl/chs_engine.sv]
// ----------------------------------------------------------------------------
// chs_engine
// Sequencer with bucket head and node memories: hash, walk chain, insert.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_engine (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  chs_pkg::req_t         req,
    input  wire                   res_take,
    output chs_pkg::res_t         res,
    output chs_pkg::eng_stat_t    stat
);
    import chs_pkg::*;

    state_t            state_reg, state_next;
    logic [BKT_W-1:0]  clr_reg, clr_next;
    logic [USED_W-1:0] used_reg, used_next;
    action_t           act_reg, act_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [BKT_W-1:0]  bkt_reg, bkt_next;
    ptr_t              head_reg, head_next;
    logic [NODE_W-1:0] ptr_reg, ptr_next;
    res_t              res_reg, res_next;

    ptr_t              head_mem [BUCKETS];
    node_t             node_mem [POOL_NODES];
    ptr_t              head_rdata_reg;
    node_t             node_rdata_reg;

    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    ptr_t              head_wdata;
    logic              node_we;
    logic [NODE_W-1:0] node_waddr;
    node_t             node_wdata;
    logic [NODE_W-1:0] node_raddr;

    logic              mod_done;
    logic [BKT_W-1:0]  mod_rem;

    chs_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (req.key),
        .divisor  (req.divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        key_reg  <= key_next;
        bkt_reg  <= bkt_next;
        head_reg <= head_next;
        ptr_reg  <= ptr_next;
        res_reg  <= res_next;
    end

    // Head memory: one write port, one registered read at the hashed bucket.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rdata_reg <= head_mem[mod_rem];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        used_next  = used_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        bkt_next   = bkt_reg;
        head_next  = head_reg;
        ptr_next   = ptr_reg;
        res_next   = res_reg;
        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = '0;
        node_we    = 1'b0;
        node_waddr = used_reg[NODE_W-1:0];
        node_wdata = '0;
        node_raddr = node_rdata_reg.link.idx;
        stat       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (start)
                begin
                    act_next   = req.action;
                    key_next   = req.key;
                    res_next   = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // Head read issues at the edge that ends here.
                if (mod_done)
                begin
                    bkt_next   = mod_rem;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                head_next  = head_rdata_reg;
                node_raddr = head_rdata_reg.idx;
                ptr_next   = head_rdata_reg.idx;
                state_next = head_rdata_reg.valid ? ST_WALK : ST_UPDATE;
            end
            ST_WALK:
            begin
                if (node_rdata_reg.key == key_reg)
                begin
                    res_next.found      = 1'b1;
                    res_next.node_index = ptr_reg;
                    state_next          = ST_RESULT;
                end
                else if (node_rdata_reg.link.valid)
                begin
                    ptr_next = node_rdata_reg.link.idx;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (used_reg < USED_W'(POOL_NODES))
                    begin
                        // Push the new node at the head of the chain.
                        node_we             = 1'b1;
                        node_wdata.key      = key_reg;
                        node_wdata.link     = head_reg;
                        head_we             = 1'b1;
                        head_wdata.valid    = 1'b1;
                        head_wdata.idx      = used_reg[NODE_W-1:0];
                        used_next           = used_reg + 1'b1;
                        res_next.inserted   = 1'b1;
                        res_next.node_index = used_reg[NODE_W-1:0];
                    end
                    else
                    begin
                        res_next.pool_full = 1'b1;
                    end
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                stat.res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[rtl/chs_checker.sv]
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the chained hash set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_set_defines.svh"

module chs_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);

    // A stalled result holds.
    `CHS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // At most one outcome flag per result.
    `CHS_ASSERT_NOW(a_one_outcome, m_tvalid, $onehot0(m_tdata[2:0]), "several outcome flags set")

    // Node index is zero unless the key was found or inserted.
    `CHS_ASSERT_NOW(a_idx_zero, m_tvalid && !m_tdata[0] && !m_tdata[1], m_tdata[14:3] == 12'd0, "node index set on a miss")

    // One item at a time: accepting an item drops ready.
    `CHS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

endmodule

bind chained_hash_set chs_checker u_chs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the chained hash set. Finds and inserts go in through
// the slave stream with random bursts and gaps. The result stream stalls on a
// pattern of its own. Each accepted request is run through a local copy of the
// bucket table and the node pool, and every result is compared field by field
// against it. Phases under several bucket counts (the clamped extremes among
// them) stress chain walks and rehash misses.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import chs_pkg::*;

    localparam int QUIET_LIMIT = 20000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES = 60;      // settle time after the last result

    typedef struct {
        action_t          act;
        logic [KEY_W-1:0] key;
    } hash_req_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // [31:0] key
    logic [0:0]  s_tuser = '0;    // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] found, [1] inserted, [2] pool_full,
                                  // [14:3] node_index, [15] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    chained_hash_set dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow copy of the table: bucket heads, node pool, pool fill level and
    // the bucket count register.
    // ------------------------------------------------------------------------
    ptr_t              bucket_heads [BUCKETS];
    node_t             node_pool    [POOL_NODES];
    logic [USED_W-1:0] used_count;
    logic [CFG_W-1:0]  bucket_cfg;

    hash_req_t         pending_reqs[$];
    res_t              expected_results[$];
    logic [KEY_W-1:0]  known_keys[$];

    int error_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int hit_count     = 0;
    int insert_count  = 0;
    int full_count    = 0;
    int miss_count    = 0;
    int cfg_count     = 0;

    // Hash the key into the active bucket range, walk the chain, and apply an
    // insert to the shadow table when the key is absent.
    function automatic res_t lookup_or_insert(action_t act, logic [KEY_W-1:0] key);
        int unsigned nb;
        int unsigned bkt;
        int unsigned steps;
        ptr_t        p;
        res_t        r;
        nb = bucket_cfg;
        if (nb < 2) nb = 2;             // counts below two act as two
        if (nb > BUCKETS) nb = BUCKETS; // counts above the table act as full size
        bkt = key % nb;
        r = '0;
        p = bucket_heads[bkt];
        steps = 0;
        while (p.valid && !r.found && steps < POOL_NODES) begin
            if (node_pool[p.idx].key == key) begin
                r.found      = 1'b1;
                r.node_index = p.idx;
            end
            else begin
                p = node_pool[p.idx].link;
            end
            steps++;
        end
        if (!r.found && act == ACT_INSERT) begin
            if (used_count < POOL_NODES) begin
                node_pool[used_count[NODE_W-1:0]].key  = key;
                node_pool[used_count[NODE_W-1:0]].link = bucket_heads[bkt];
                bucket_heads[bkt].valid = 1'b1;
                bucket_heads[bkt].idx   = used_count[NODE_W-1:0];
                r.inserted   = 1'b1;
                r.node_index = used_count[NODE_W-1:0];
                used_count++;
            end
            else begin
                // pool exhausted: table left untouched
                r.pool_full = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: pops pending requests, sends them in bursts of random
    // length with random gaps, and predicts each one as it is accepted.
    // ------------------------------------------------------------------------
    hash_req_t on_bus;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge clk) begin
        res_t r;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                r = lookup_or_insert(on_bus.act, on_bus.key);
                expected_results.push_back(r);
                sent_count++;
                if (r.found) hit_count++;
                else if (r.inserted) insert_count++;
                else if (r.pool_full) full_count++;
                else miss_count++;
            end
            // hold the item until it is taken
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0) begin
                    on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus.key;
                    s_tuser  <= on_bus.act;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else begin
                        burst_left--;
                    end
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each accepted result against the oldest
    // prediction and drives m_tready from a stall pattern that switches
    // between always open, random stalls and one-in-four acceptance.
    // ------------------------------------------------------------------------
    rx_mode_t    rx_mode   = RX_OPEN;
    int          mode_left = 0;
    logic [1:0]  rx_tick   = '0;

    always @(posedge clk) begin
        res_t exp_r;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item, m_tdata=%h", m_tdata);
                    error_count++;
                end
                else begin
                    exp_r = expected_results.pop_front();
                    checked_count++;
                    if (m_tdata[0] !== exp_r.found) begin
                        $error("found: expected %0d, actual %0d", exp_r.found, m_tdata[0]);
                        error_count++;
                    end
                    if (m_tdata[1] !== exp_r.inserted) begin
                        $error("inserted: expected %0d, actual %0d",
                               exp_r.inserted, m_tdata[1]);
                        error_count++;
                    end
                    if (m_tdata[2] !== exp_r.pool_full) begin
                        $error("pool_full: expected %0d, actual %0d",
                               exp_r.pool_full, m_tdata[2]);
                        error_count++;
                    end
                    if (m_tdata[14:3] !== exp_r.node_index) begin
                        $error("node_index: expected %0d, actual %0d",
                               exp_r.node_index, m_tdata[14:3]);
                        error_count++;
                    end
                end
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(32, 200);
            end
            else begin
                mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
                default:   m_tready <= (rx_tick == 2'd0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long.
    // The limit covers the clearing pass after reset and the longest chain
    // walk under a small bucket count.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_req(action_t act, logic [KEY_W-1:0] key);
        hash_req_t req;
        req.act = act;
        req.key = key;
        if (act == ACT_INSERT) known_keys.push_back(key);
        pending_reqs.push_back(req);
    endtask

    // About reuse_pct percent are keys seen before, so finds hit and inserts hit duplicates; the
    // rest are corner patterns, small keys that pile into low buckets, and
    // fully random keys.
    function automatic logic [KEY_W-1:0] pick_key(int reuse_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < reuse_pct && known_keys.size() != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        if (roll < reuse_pct + 6) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (roll < reuse_pct + 20)
            return $urandom_range(0, 4095);
        return $urandom;
    endfunction

    task automatic queue_mix(int n, int insert_pct, int reuse_pct);
        action_t act;
        for (int i = 0; i < n; i++) begin
            act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_FIND;
            push_req(act, pick_key(reuse_pct));
        end
    endtask

    // Sample at the falling edge so the driver and monitor have settled.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Write the bucket count only with the engine idle.
    task automatic write_bucket_count(logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bucket_cfg = value;
        cfg_count++;
    endtask

    initial begin
        for (int b = 0; b < BUCKETS; b++) bucket_heads[b] = '0;
        used_count = '0;
        bucket_cfg = CFG_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset bucket count: absent find, insert, duplicate insert,
        // extreme keys, and a chain of three in bucket zero.
        push_req(ACT_FIND,   32'h0000_0000);
        push_req(ACT_INSERT, 32'h0000_0000);
        push_req(ACT_INSERT, 32'h0000_0000);
        push_req(ACT_FIND,   32'h0000_0000);
        push_req(ACT_INSERT, 32'hFFFF_FFFF);
        push_req(ACT_FIND,   32'hFFFF_FFFF);
        push_req(ACT_INSERT, 32'd1021);
        push_req(ACT_INSERT, 32'd2042);
        push_req(ACT_FIND,   32'd1021);
        push_req(ACT_FIND,   32'd3063);      // walks the whole chain and misses
        push_req(ACT_INSERT, 32'h8000_0000);
        push_req(ACT_FIND,   32'h7FFF_FFFF);

        // Count of zero acts as two: stored keys now hash elsewhere, so the
        // same key can be missed and stored a second time.
        write_bucket_count(11'd0);
        push_req(ACT_FIND,   32'd1021);
        push_req(ACT_INSERT, 32'd1021);
        push_req(ACT_FIND,   32'd1021);
        push_req(ACT_FIND,   32'd0);
        push_req(ACT_INSERT, 32'd3);
        push_req(ACT_INSERT, 32'd4);
        queue_mix(80, 50, 45);

        // Count above the table size acts as full size.
        write_bucket_count(11'd2047);
        queue_mix(150, 55, 40);

        write_bucket_count(11'd1);
        queue_mix(60, 40, 50);

        write_bucket_count(11'd1024);
        queue_mix(300, 50, 40);

        repeat (5) begin
            write_bucket_count(11'($urandom_range(3, 1023)));
            queue_mix(150, 50, 45);
        end

        write_bucket_count(11'd2);
        queue_mix(60, 35, 55);

        // Close out at full size: lookups and inserts against everything stored.
        write_bucket_count(11'd1024);
        queue_mix(250, 60, 50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d requests over %0d bucket count writes:",
                 checked_count, sent_count, cfg_count);
        $display("  %0d hits, %0d inserts, %0d pool-full refusals, %0d misses",
                 hit_count, insert_count, full_count, miss_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[chained_hash_set.f]
+incdir+rtl
rtl/chs_pkg.sv
rtl/chs_mod.sv
rtl/chs_engine.sv
rtl/chained_hash_set.sv
rtl/chs_checker.sv
tb/sv/testbench.sv
